FILE: sv/glyph_blit_clipped_unit_assert.svh
// Assertion macros used by the back end of the glyph blit unit.
`ifndef GLYPH_BLIT_CLIPPED_UNIT_ASSERT_SVH
`define GLYPH_BLIT_CLIPPED_UNIT_ASSERT_SVH

// clocked check, off during reset
`define GBC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// clocked check, also during reset
`define GBC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: sv/gbc_pkg.sv
// Types and constants of the glyph blit unit.
package gbc_pkg;

   localparam int DIM_W    = 13;
   localparam int PITCH_W  = 10;
   localparam int MODE_W   = 2;
   localparam int ADDR_W   = 24;
   localparam int COL_W    = 16;
   localparam int CNT_W    = 4;
   localparam int BIT_W    = 3;
   localparam int CSR_IDX_W = 3;
   localparam int Q_DEPTH  = 4;
   localparam int Q_PTR_W  = $clog2(Q_DEPTH);
   localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

   localparam logic [MODE_W-1:0] MODE_MONO = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GRAY = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_DEST_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_WIDTH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH_ROWS  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_PITCH   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAW_MODE   = 3'd7;

   typedef struct packed {
      logic [DIM_W-1:0]   dest_width;
      logic [DIM_W-1:0]   dest_height;
      logic [DIM_W-1:0]   origin_x;
      logic [DIM_W-1:0]   origin_y;
      logic [DIM_W-1:0]   glyph_width;
      logic [DIM_W-1:0]   glyph_rows;
      logic [PITCH_W-1:0] row_pitch;
      logic [MODE_W-1:0]  draw_mode;
   } cfg_type;

   // one queued item: a run of pixels on one destination row
   typedef struct packed {
      logic [COL_W-1:0]  col;
      logic [CNT_W-1:0]  count;
      logic [7:0]        src;
      logic              gray;
      logic              row_in;
      logic [ADDR_W-1:0] row_base;
      logic [DIM_W-1:0]  max_row;
   } job_type;

endpackage

FILE: sv/gbc_front.sv
// Front end: configuration registers, glyph counters, item classification.
module gbc_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [gbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gbc_pkg::DIM_W-1:0]          csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [7:0]                         req_src_byte,
   input  logic                               req_glyph_start,
   input  logic                               q_full,
   output logic                               q_push,
   output gbc_pkg::job_type                   q_job,
   output gbc_pkg::cfg_type                   cfg
);
   import gbc_pkg::*;

   cfg_type            cfg_ff, cfg_in;
   logic [DIM_W-1:0]   row_count_ff, row_count_in;
   logic [DIM_W-1:0]   byte_in_row_ff, byte_in_row_in;
   logic [DIM_W-1:0]   max_row_ff, max_row_in;

   logic               accept;
   logic [DIM_W-1:0]   rc, bir, mr;
   logic [DIM_W+1:0]   bottom, mx;
   logic [DIM_W+1:0]   yy;
   logic [COL_W-1:0]   x0, gw16, diff;
   logic [DIM_W:0]     bir_inc;
   logic               advance, wrap;
   logic [CNT_W-1:0]   n;
   logic [2*DIM_W-1:0] prod;

   assign accept    = req_valid && !req_stall;
   assign req_stall = q_full;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DEST_WIDTH:  cfg_in.dest_width  = csr_write_data;
            CSR_DEST_HEIGHT: cfg_in.dest_height = csr_write_data;
            CSR_ORIGIN_X:    cfg_in.origin_x    = csr_write_data;
            CSR_ORIGIN_Y:    cfg_in.origin_y    = csr_write_data;
            CSR_GLYPH_WIDTH: cfg_in.glyph_width = csr_write_data;
            CSR_GLYPH_ROWS:  cfg_in.glyph_rows  = csr_write_data;
            CSR_ROW_PITCH:   cfg_in.row_pitch   = csr_write_data[PITCH_W-1:0];
            CSR_DRAW_MODE:   cfg_in.draw_mode   = csr_write_data[MODE_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      // sticky bottom extent, signed sum then clamp
      bottom = {2'b00, cfg_ff.glyph_rows} + {{2{cfg_ff.origin_y[DIM_W-1]}}, cfg_ff.origin_y};
      if (!bottom[DIM_W+1] && (bottom > {2'b00, max_row_ff}))
         mx = bottom;
      else
         mx = {2'b00, max_row_ff};
      rc  = req_glyph_start ? '0 : row_count_ff;
      bir = req_glyph_start ? '0 : byte_in_row_ff;
      if (!req_glyph_start)
         mr = max_row_ff;
      else if (mx >= {2'b00, cfg_ff.dest_height})
         mr = cfg_ff.dest_height;
      else
         mr = mx[DIM_W-1:0];

      x0      = {bir, 3'b000};
      gw16    = {3'b000, cfg_ff.glyph_width};
      diff    = gw16 - x0;
      bir_inc = {1'b0, bir} + 14'd1;
      advance = 1'b0;
      wrap    = 1'b0;
      n       = '0;
      q_job.col = x0;
      if (rc < cfg_ff.glyph_rows) begin
         case (cfg_ff.draw_mode)
            MODE_MONO: begin
               if (cfg_ff.row_pitch != '0) begin
                  advance = 1'b1;
                  wrap    = bir_inc >= {4'b0000, cfg_ff.row_pitch};
                  if (gw16 > x0)
                     n = (diff > 16'd8) ? 4'd8 : diff[CNT_W-1:0];
               end
            end
            MODE_GRAY: begin
               q_job.col = {3'b000, bir};
               if (cfg_ff.glyph_width != '0) begin
                  advance = 1'b1;
                  wrap    = bir_inc >= {1'b0, cfg_ff.glyph_width};
                  n       = 4'd1;
               end
            end
            default: advance = 1'b0;
         endcase
      end

      yy   = {{2{cfg_ff.origin_y[DIM_W-1]}}, cfg_ff.origin_y} + {2'b00, rc};
      prod = yy[DIM_W-1:0] * cfg_ff.dest_width;

      q_job.count    = n;
      q_job.src      = req_src_byte;
      q_job.gray     = (cfg_ff.draw_mode == MODE_GRAY);
      q_job.row_in   = !yy[DIM_W+1] && (yy[DIM_W:0] < {1'b0, cfg_ff.dest_height});
      q_job.row_base = prod[ADDR_W-1:0];
      q_job.max_row  = mr;
      q_push         = accept && (n != '0);

      row_count_in   = row_count_ff;
      byte_in_row_in = byte_in_row_ff;
      max_row_in     = max_row_ff;
      if (accept) begin
         max_row_in     = mr;
         row_count_in   = rc;
         byte_in_row_in = bir;
         if (advance) begin
            if (wrap) begin
               byte_in_row_in = '0;
               row_count_in   = rc + 13'd1;
            end else begin
               byte_in_row_in = bir_inc[DIM_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_width  <= 13'd256;
         cfg_ff.dest_height <= 13'd256;
         cfg_ff.origin_x    <= '0;
         cfg_ff.origin_y    <= '0;
         cfg_ff.glyph_width <= '0;
         cfg_ff.glyph_rows  <= '0;
         cfg_ff.row_pitch   <= '0;
         cfg_ff.draw_mode   <= MODE_MONO;
         row_count_ff       <= '0;
         byte_in_row_ff     <= '0;
         max_row_ff         <= '0;
      end else begin
         cfg_ff         <= cfg_in;
         row_count_ff   <= row_count_in;
         byte_in_row_ff <= byte_in_row_in;
         max_row_ff     <= max_row_in;
      end
   end

endmodule

FILE: sv/gbc_queue.sv
// Short item queue between front and back end.
module gbc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  gbc_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             pop_valid,
   output gbc_pkg::job_type pop_job
);
   import gbc_pkg::*;

   job_type              mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = rd_ptr_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push)
         mem_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: sv/gbc_back.sv
// Back end: unpacks a queued run into one clipped pixel write per cycle while rsp_ is not stalled.
`include "glyph_blit_clipped_unit_assert.svh"
module gbc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  gbc_pkg::cfg_type              cfg,
   input  logic                          q_valid,
   input  gbc_pkg::job_type              q_job,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_write_enable,
   output logic [gbc_pkg::ADDR_W-1:0]    rsp_write_address,
   output logic [7:0]                    rsp_write_value,
   output logic [gbc_pkg::DIM_W-1:0]     rsp_max_row,
   output logic                          rsp_last
);
   import gbc_pkg::*;

   job_type            job_ff, job_in;
   logic               job_valid_ff, job_valid_in;
   logic [BIT_W-1:0]   bit_idx_ff, bit_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               we_ff, we_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [7:0]         value_ff, value_in;
   logic [DIM_W-1:0]   max_row_ff, max_row_in;
   logic               last_ff, last_in;

   logic               out_free, fire, last_pix;
   logic [COL_W:0]     col_b;
   logic [COL_W+1:0]   xx;
   logic               on_raster;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = job_valid_ff && out_free;
   assign last_pix = ({1'b0, bit_idx_ff} == (job_ff.count - 4'd1));
   assign q_pop    = q_valid && (!job_valid_ff || (fire && last_pix));

   always_comb begin
      col_b  = {1'b0, job_ff.col} + {{(COL_W+1-BIT_W){1'b0}}, bit_idx_ff};
      xx     = {{(COL_W+2-DIM_W){cfg.origin_x[DIM_W-1]}}, cfg.origin_x} + {1'b0, col_b};
      on_raster = job_ff.row_in && !xx[COL_W+1]
                  && (xx[COL_W:0] < {{(COL_W+1-DIM_W){1'b0}}, cfg.dest_width});

      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      bit_idx_in   = bit_idx_ff;
      if (q_pop) begin
         job_in       = q_job;
         job_valid_in = 1'b1;
         bit_idx_in   = '0;
      end else if (fire && last_pix) begin
         job_valid_in = 1'b0;
      end else if (fire) begin
         bit_idx_in = bit_idx_ff + 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      we_in        = we_ff;
      addr_in      = addr_ff;
      value_in     = value_ff;
      max_row_in   = max_row_ff;
      last_in      = last_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         we_in        = on_raster;
         addr_in      = on_raster ? ({{(ADDR_W-COL_W-1){1'b0}}, xx[COL_W:0]} + job_ff.row_base)
                                  : '0;
         value_in     = job_ff.gray ? job_ff.src : {7'd0, job_ff.src[~bit_idx_ff]};
         max_row_in   = job_ff.max_row;
         last_in      = last_pix;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      bit_idx_ff <= bit_idx_in;
      we_ff      <= we_in;
      addr_ff    <= addr_in;
      value_ff   <= value_in;
      max_row_ff <= max_row_in;
      last_ff    <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_enable  = we_ff;
   assign rsp_write_address = addr_ff;
   assign rsp_write_value   = value_ff;
   assign rsp_max_row       = max_row_ff;
   assign rsp_last          = last_ff;

   `GBC_ASSERT(a_job_nonempty, job_valid_ff |-> (job_ff.count != '0), "empty run held")
   `GBC_ASSERT(a_idx_in_run, job_valid_ff |-> ({1'b0, bit_idx_ff} < job_ff.count), "pixel index past run")
   `GBC_ASSERT(a_run_retires, (fire && last_pix && !q_valid) |=> !job_valid_ff, "finished run not retired")
   `GBC_ASSERT_ALWAYS(a_reset_idle, reset |=> (!rsp_valid_ff && !job_valid_ff), "not idle after reset")

endmodule

FILE: sv/glyph_blit_clipped_unit.sv
// Glyph blit unit: unpacks glyph source bytes into clipped raster pixel writes.
//
// Configure through csr_ (write enable, index, data) while the unit is idle.
// Source bytes enter on req_ (valid/stall); req_glyph_start marks the first
// byte of a glyph. Pixel writes leave on rsp_ (valid/stall), one per cycle
// unless rsp_stall holds them, with rsp_last on the final pixel of each byte.
// A mono byte yields up to 8 pixels and occupies the back end until all of
// them are out; a gray byte yields one pixel; bytes with no pixels are taken
// by the front end and never enter the queue. Sustained rate is set by the single
// pixel-write output register: one pixel per cycle while rsp_ is not stalled.
// A byte goes through the queue, the run register and the output register to rsp_.
// A 4-entry queue decouples byte intake from pixel output; req_stall rises
// only while that queue is full.
// Reset (synchronous) restores register defaults, clears counters, the sticky
// max row, the queue and the output. A stalled rsp_ item holds; the back end
// waits and the queue keeps absorbing bytes until full.
module glyph_blit_clipped_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [gbc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gbc_pkg::DIM_W-1:0]         csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_src_byte,
   input  logic                              req_glyph_start,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_write_enable,
   output logic [gbc_pkg::ADDR_W-1:0]        rsp_write_address,
   output logic [7:0]                        rsp_write_value,
   output logic [gbc_pkg::DIM_W-1:0]         rsp_max_row,
   output logic                              rsp_last
);
   import gbc_pkg::*;

   cfg_type cfg;
   job_type push_job, pop_job;
   logic    push, pop, full, pop_valid;

   gbc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_src_byte     (req_src_byte),
      .req_glyph_start  (req_glyph_start),
      .q_full           (full),
      .q_push           (push),
      .q_job            (push_job),
      .cfg              (cfg)
   );

   gbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (full),
      .pop_valid (pop_valid),
      .pop_job   (pop_job)
   );

   gbc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .q_valid           (pop_valid),
      .q_job             (pop_job),
      .q_pop             (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_write_address (rsp_write_address),
      .rsp_write_value   (rsp_write_value),
      .rsp_max_row       (rsp_max_row),
      .rsp_last          (rsp_last)
   );

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the glyph blit unit: predicted pixel writes against DUT output.
`timescale 1ns / 100ps

module testbench;
   import gbc_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNSUPPORTED = 2'd2;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [7:0] src_byte;
      logic       glyph_start;
   } src_item_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        value;
      logic [DIM_W-1:0]  max_row;
      logic              last;
   } pixel_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DIM_W-1:0]     csr_write_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_src_byte = '0;
   logic                 req_glyph_start = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_write_enable;
   logic [ADDR_W-1:0]    rsp_write_address;
   logic [7:0]           rsp_write_value;
   logic [DIM_W-1:0]     rsp_max_row;
   logic                 rsp_last;

   src_item_type byte_queue [$];
   pixel_type    pixel_queue [$];

   // predictor copy of registers and counters
   int                dest_w = 256;
   int                dest_h = 256;
   int                org_x = 0;
   int                org_y = 0;
   int                glyph_w = 0;
   int                glyph_h = 0;
   int                pitch = 0;
   logic [MODE_W-1:0] mode = MODE_MONO;
   int                row_idx = 0;
   int                byte_idx = 0;
   int                max_row_q = 0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int errors = 0;
   int bytes_sent = 0;
   int pixels_checked = 0;
   int pixels_on = 0;
   int settings = 0;
   int quiet = 0;

   glyph_blit_clipped_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_src_byte      (req_src_byte),
      .req_glyph_start   (req_glyph_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_write_address (rsp_write_address),
      .rsp_write_value   (rsp_write_value),
      .rsp_max_row       (rsp_max_row),
      .rsp_last          (rsp_last)
   );

   always #1 clock = ~clock;

   function automatic pixel_type place_pixel(int col, int row, logic [7:0] value);
      pixel_type p;
      int xx;
      int yy;
      xx = org_x + col;
      yy = org_y + row;
      p.we = (xx >= 0 && xx < dest_w && yy >= 0 && yy < dest_h);
      p.addr = p.we ? ADDR_W'(xx + yy * dest_w) : '0;
      p.value = value;
      p.max_row = DIM_W'(max_row_q);
      p.last = 1'b0;
      return p;
   endfunction

   function automatic void blit_byte(logic [7:0] src, logic start);
      pixel_type px [$];
      int bottom;
      int x0;
      int avail;
      if (start) begin
         bottom = glyph_h + org_y;
         if (bottom > max_row_q) max_row_q = bottom;
         if (max_row_q >= dest_h) max_row_q = dest_h;
         row_idx = 0;
         byte_idx = 0;
      end
      if (row_idx >= glyph_h) return;
      if (mode == MODE_MONO && pitch != 0) begin
         x0 = byte_idx * 8;
         avail = (glyph_w > x0) ? glyph_w - x0 : 0;
         if (avail > 8) avail = 8;
         for (int b = 0; b < avail; b++) begin
            px.push_back(place_pixel(x0 + b, row_idx, {7'd0, src[7 - b]}));
         end
         byte_idx++;
         if (byte_idx >= pitch) begin
            byte_idx = 0;
            row_idx++;
         end
      end else if (mode == MODE_GRAY && glyph_w != 0) begin
         px.push_back(place_pixel(byte_idx, row_idx, src));
         byte_idx++;
         if (byte_idx >= glyph_w) begin
            byte_idx = 0;
            row_idx++;
         end
      end
      if (px.size() != 0) px[px.size() - 1].last = 1'b1;
      foreach (px[i]) pixel_queue.push_back(px[i]);
   endfunction

   task automatic report(string what, longint got, longint want);
      errors++;
      $display("MISMATCH %s: got %0h expected %0h at pixel %0d",
               what, got, want, pixels_checked);
   endtask

   // driver
   always @(posedge clock) begin
      src_item_type next_byte;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            blit_byte(req_src_byte, req_glyph_start);
            bytes_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_byte = byte_queue.pop_front();
               req_valid <= 1'b1;
               req_src_byte <= next_byte.src_byte;
               req_glyph_start <= next_byte.glyph_start;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pixel_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pixel_queue.size() == 0) begin
               report("pixel write with none due", 1, 0);
            end else begin
               due = pixel_queue.pop_front();
               if (rsp_write_enable !== due.we)
                  report("write_enable", rsp_write_enable, due.we);
               if (rsp_write_address !== due.addr)
                  report("write_address", rsp_write_address, due.addr);
               if (rsp_write_value !== due.value)
                  report("write_value", rsp_write_value, due.value);
               if (rsp_max_row !== due.max_row)
                  report("max_row", rsp_max_row, due.max_row);
               if (rsp_last !== due.last)
                  report("last", rsp_last, due.last);
               if (due.we) pixels_on++;
               pixels_checked++;
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("glyph_blit_clipped_unit verification failed");
            $finish;
         end
      end
   end

   task automatic send(logic [7:0] b, logic s);
      src_item_type it;
      it.src_byte = b;
      it.glyph_start = s;
      byte_queue.push_back(it);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (byte_queue.size() != 0 || req_valid || pixel_queue.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int value);
      logic [DIM_W-1:0] d;
      d = value[DIM_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= d;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_DEST_WIDTH:  dest_w = int'(d);
         CSR_DEST_HEIGHT: dest_h = int'(d);
         CSR_ORIGIN_X:    org_x = int'($signed(d));
         CSR_ORIGIN_Y:    org_y = int'($signed(d));
         CSR_GLYPH_WIDTH: glyph_w = int'(d);
         CSR_GLYPH_ROWS:  glyph_h = int'(d);
         CSR_ROW_PITCH:   pitch = int'(d[PITCH_W-1:0]);
         CSR_DRAW_MODE:   mode = d[MODE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic configure(int dw, int dh, int ox, int oy, int gw, int gr, int pt,
                            logic [MODE_W-1:0] md);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(CSR_DEST_WIDTH, dw);
      csr_write(CSR_DEST_HEIGHT, dh);
      csr_write(CSR_ORIGIN_X, ox);
      csr_write(CSR_ORIGIN_Y, oy);
      csr_write(CSR_GLYPH_WIDTH, gw);
      csr_write(CSR_GLYPH_ROWS, gr);
      csr_write(CSR_ROW_PITCH, pt);
      csr_write(CSR_DRAW_MODE, md);
      settings++;
      @(negedge clock);
   endtask

   function automatic int random_origin();
      int pick;
      pick = $urandom_range(19);
      if (pick == 0) return -4096;
      if (pick == 1) return 4095;
      return int'($urandom_range(0, 40)) - 20;
   endfunction

   task automatic random_setup();
      int dw;
      int dh;
      int ox;
      int oy;
      int gw;
      int gr;
      int pt;
      int pick;
      logic [MODE_W-1:0] md;
      dw = ($urandom_range(9) == 0) ? 4096 : $urandom_range(1, 24);
      dh = ($urandom_range(9) == 0) ? 4096 : $urandom_range(1, 12);
      ox = random_origin();
      oy = random_origin();
      gw = ($urandom_range(19) == 0) ? 4096 : $urandom_range(0, 20);
      gr = ($urandom_range(19) == 0) ? 4096 : $urandom_range(0, 5);
      pick = $urandom_range(9);
      md = (pick < 5) ? MODE_MONO : (pick < 9) ? MODE_GRAY : MODE_UNSUPPORTED;
      pick = $urandom_range(9);
      if (pick < 6) pt = (gw + 7) / 8;
      else if (pick < 8) pt = (gw + 7) / 8 + 1;
      else if (pick == 8) pt = 0;
      else pt = $urandom_range(0, 512);
      if (pt > 512) pt = 512;
      configure(dw, dh, ox, oy, gw, gr, pt, md);
   endtask

   function automatic int glyph_bytes();
      int full;
      if (mode == MODE_MONO) full = glyph_h * pitch;
      else if (mode == MODE_GRAY) full = glyph_h * glyph_w;
      else full = 0;
      if (full == 0) full = $urandom_range(1, 3);
      if (full > 24) full = 24;
      return full + $urandom_range(0, 1);
   endfunction

   task automatic set_idling(int phase);
      case (phase)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 57; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 57; end
         default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
   endtask

   initial begin
      int seg_bytes;
      int n;
      logic noisy;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // counters still zero from reset, no glyph start; padding bits; bytes past the glyph
      configure(256, 256, 0, 0, 12, 2, 2, MODE_MONO);
      send(8'hFF, 1'b0);
      send(8'hA5, 1'b0);
      send(8'h00, 1'b0);
      send(8'h5A, 1'b0);
      send(8'hFF, 1'b0);
      wait_drained();
      send(8'h81, 1'b1);

      // negative origin, clipping on left, right and top, whole padding byte, clamped max row
      configure(5, 3, -3, -1, 16, 5, 3, MODE_MONO);
      send(8'hF0, 1'b1);
      send(8'h0F, 1'b0);
      send(8'hAA, 1'b0);
      send(8'h55, 1'b0);
      send(8'hCC, 1'b0);

      // gray at the far corner of the largest raster
      configure(4096, 4096, 4095, 4095, 3, 2, 0, MODE_GRAY);
      send(8'h00, 1'b1);
      send(8'hFF, 1'b0);
      send(8'h80, 1'b0);
      send(8'h7F, 1'b0);
      send(8'h01, 1'b0);
      send(8'h55, 1'b0);

      configure(1, 1, -4096, -4096, 4096, 4096, 0, MODE_MONO);
      send(8'h3C, 1'b1);
      configure(1, 1, -4096, -4096, 4096, 4096, 512, MODE_MONO);
      send(8'hC3, 1'b1);
      send(8'hFF, 1'b0);
      configure(8, 8, 2, 1, 0, 4, 4, MODE_GRAY);
      send(8'h77, 1'b1);
      configure(8, 8, 2, 6, 4, 4, 1, MODE_UNSUPPORTED);
      send(8'h99, 1'b1);
      send(8'h66, 1'b0);

      for (int seg = 0; seg < 13; seg++) begin
         random_setup();
         set_idling(seg % 4);
         seg_bytes = 0;
         while (seg_bytes < 25) begin
            n = glyph_bytes();
            noisy = ($urandom_range(9) == 0);
            for (int i = 0; i < n; i++) begin
               send(8'($urandom_range(255)), noisy ? 1'($urandom_range(1)) : (i == 0));
            end
            seg_bytes += n;
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pixel_queue.size() != 0) report("pixel writes never seen", pixel_queue.size(), 0);
      $display("run: %0d source bytes over %0d register settings, mono/gray/unsupported",
               bytes_sent, settings);
      $display("run: %0d pixel writes checked, %0d on the raster", pixels_checked, pixels_on);
      if (errors == 0) begin
         $display("glyph_blit_clipped_unit verification clean");
      end else begin
         $display("glyph_blit_clipped_unit verification failed");
      end
      $finish;
   end

endmodule
